FILE: hw/rtl/kpe_pkg.sv
// ----------------------------------------------------------------------------
// kpe_pkg
// Shared types, constants and register codes for the key press event
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package kpe_pkg;

  // item field widths
  localparam int MASK_W     = 16;
  localparam int KEY_W      = 4;
  localparam int TIME_W     = 32;
  localparam int EV_W       = 3;
  localparam int CFG_TIME_W = 16;
  localparam int FEAT_W     = 4;

  // number of mask bits that are real keys
  localparam int NUM_KEYS = 16;

  // debounce filter constants
  localparam int FILT_W     = 8;
  localparam int LEAK_SHIFT = 5;
  localparam int TC         = 7;
  localparam int UTH        = 215;
  localparam int LTH        = 7;

  // register port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register reset values
  localparam logic [CFG_TIME_W-1:0] PRESS_TIME_RST  = 16'd150;
  localparam logic [CFG_TIME_W-1:0] DOUBLE_TIME_RST = 16'd250;
  localparam logic [CFG_TIME_W-1:0] LONG_TIME_RST   = 16'd600;
  localparam logic [CFG_TIME_W-1:0] REPEAT_TIME_RST = 16'd300;
  localparam logic [FEAT_W-1:0]     FEATURES_RST    = 4'd0;

  // register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_PRESS_TIME  = 3'd0,
    REG_DOUBLE_TIME = 3'd1,
    REG_LONG_TIME   = 3'd2,
    REG_REPEAT_TIME = 3'd3,
    REG_FEATURES    = 3'd4
  } reg_idx_t;

  // feature enable bit positions
  localparam int FEAT_DOUBLE = 0;
  localparam int FEAT_LONG   = 1;
  localparam int FEAT_REPEAT = 2;
  localparam int FEAT_RPT_EV = 3;

  // event codes
  typedef enum logic [EV_W-1:0] {
    EV_NONE   = 3'd0,
    EV_DOWN   = 3'd1,
    EV_UP     = 3'd2,
    EV_PRESS  = 3'd3,
    EV_DPRESS = 3'd4,
    EV_LONG   = 3'd5,
    EV_RPT    = 3'd6
  } event_t;

  // debounce phases
  typedef enum logic [1:0] {
    PH_WAIT_EDGE    = 2'd0,
    PH_FILTER       = 2'd1,
    PH_WAIT_RELEASE = 2'd2
  } phase_t;

  // press classifier states
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PRESS   = 3'd1,
    ST_PRESSL  = 3'd2,
    ST_REPEAT  = 3'd3,
    ST_PRESS2A = 3'd4,
    ST_PRESS2B = 3'd5,
    ST_WAIT    = 3'd6
  } press_t;

  // configuration seen by the classifier
  typedef struct packed {
    logic [CFG_TIME_W-1:0] press_time;
    logic [CFG_TIME_W-1:0] double_press_time;
    logic [CFG_TIME_W-1:0] long_press_time;
    logic [CFG_TIME_W-1:0] repeat_time;
    logic [FEAT_W-1:0]     feature_enables;
  } cfg_t;

  // per-poll control from the top level to the stages
  typedef struct packed {
    logic step;   // poll moves into the result register this cycle
    logic clear;  // new key seen alone, restart both stages
  } ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kpe_in_if.sv
// ----------------------------------------------------------------------------
// kpe_in_if
// Poll channel: key mask and millisecond timestamp with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpe_in_if;
  logic                        valid;
  logic                        ready;
  logic [kpe_pkg::MASK_W-1:0]  pressed_mask;
  logic [kpe_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, output pressed_mask, output now_ms, input ready);
  modport sink   (input valid, input pressed_mask, input now_ms, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kpe_out_if.sv
// ----------------------------------------------------------------------------
// kpe_out_if
// Result channel: key event and key index with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface kpe_out_if;
  logic                       valid;
  logic                       ready;
  logic [kpe_pkg::EV_W-1:0]   key_event;
  logic [kpe_pkg::KEY_W-1:0]  key_index;
  logic                       key_index_valid;

  modport source (output valid, output key_event, output key_index,
                  output key_index_valid, input ready);
  modport sink   (input valid, input key_event, input key_index,
                  input key_index_valid, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kpe_cfg.sv
// ----------------------------------------------------------------------------
// kpe_cfg
// APB-style register block holding the timing and feature registers.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [kpe_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [kpe_pkg::DATA_W-1:0]  pwdata,
  output logic      [kpe_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output kpe_pkg::cfg_t                    cfg
);

  logic             wr_en;
  kpe_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = kpe_pkg::reg_idx_t'(paddr[kpe_pkg::ADDR_W-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_time        <= kpe_pkg::PRESS_TIME_RST;
      cfg.double_press_time <= kpe_pkg::DOUBLE_TIME_RST;
      cfg.long_press_time   <= kpe_pkg::LONG_TIME_RST;
      cfg.repeat_time       <= kpe_pkg::REPEAT_TIME_RST;
      cfg.feature_enables   <= kpe_pkg::FEATURES_RST;
    end else if (wr_en) begin
      case (idx)
        kpe_pkg::REG_PRESS_TIME:
          cfg.press_time <= pwdata[kpe_pkg::CFG_TIME_W-1:0];
        kpe_pkg::REG_DOUBLE_TIME:
          cfg.double_press_time <= pwdata[kpe_pkg::CFG_TIME_W-1:0];
        kpe_pkg::REG_LONG_TIME:
          cfg.long_press_time <= pwdata[kpe_pkg::CFG_TIME_W-1:0];
        kpe_pkg::REG_REPEAT_TIME:
          cfg.repeat_time <= pwdata[kpe_pkg::CFG_TIME_W-1:0];
        kpe_pkg::REG_FEATURES:
          cfg.feature_enables <= pwdata[kpe_pkg::FEAT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      kpe_pkg::REG_PRESS_TIME:  prdata = kpe_pkg::DATA_W'(cfg.press_time);
      kpe_pkg::REG_DOUBLE_TIME: prdata = kpe_pkg::DATA_W'(cfg.double_press_time);
      kpe_pkg::REG_LONG_TIME:   prdata = kpe_pkg::DATA_W'(cfg.long_press_time);
      kpe_pkg::REG_REPEAT_TIME: prdata = kpe_pkg::DATA_W'(cfg.repeat_time);
      kpe_pkg::REG_FEATURES:    prdata = kpe_pkg::DATA_W'(cfg.feature_enables);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kpe_filter.sv
// ----------------------------------------------------------------------------
// kpe_filter
// RC-style debouncer: wait for a rising edge, filter the level with a leaky
// 8-bit integrator, then wait for release.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_filter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire kpe_pkg::ctl_t ctl,
  input  wire logic          cur,
  output logic               lvl
);

  localparam int FW = kpe_pkg::FILT_W;

  kpe_pkg::phase_t phase, phase_next, ph;
  logic [FW-1:0]   level, level_next, lv;
  logic            prev, prev_next, pv;
  logic [FW-1:0]   r_dec, r;
  logic            hi, lo;

  // integrator arithmetic
  always_comb begin
    ph    = ctl.clear ? kpe_pkg::PH_WAIT_EDGE : phase;
    lv    = ctl.clear ? '0 : level;
    pv    = ctl.clear ? 1'b0 : prev;
    r_dec = lv - (lv >> kpe_pkg::LEAK_SHIFT);
    if (cur) begin
      r = r_dec + FW'(kpe_pkg::TC);
    end else begin
      r = r_dec - FW'(r_dec != '0);
    end
    hi = r > FW'(kpe_pkg::UTH);
    lo = r < FW'(kpe_pkg::LTH);
  end

  // phase sequencing
  always_comb begin
    phase_next = ph;
    level_next = lv;
    prev_next  = pv;
    lvl        = pv;
    case (ph)
      kpe_pkg::PH_WAIT_EDGE: begin
        if (!pv && cur) phase_next = kpe_pkg::PH_FILTER;
        prev_next = cur;
      end
      kpe_pkg::PH_FILTER: begin
        lvl = hi;
        if (hi || lo) begin
          level_next = '0;
          phase_next = kpe_pkg::PH_WAIT_RELEASE;
        end else begin
          level_next = r;
        end
      end
      default: begin
        // wait for release, also the unused code
        if (!cur) phase_next = kpe_pkg::PH_WAIT_EDGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= kpe_pkg::PH_WAIT_EDGE;
      level <= '0;
      prev  <= 1'b0;
    end else if (ctl.step) begin
      phase <= phase_next;
      level <= level_next;
      prev  <= prev_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kpe_fsm.sv
// ----------------------------------------------------------------------------
// kpe_fsm
// Press classifier: turns the debounced level and poll time into down, up,
// press, double press, long press and repeat events.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_fsm (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire kpe_pkg::ctl_t              ctl,
  input  wire kpe_pkg::cfg_t              cfg,
  input  wire logic                       b,
  input  wire logic [kpe_pkg::TIME_W-1:0] now,
  output kpe_pkg::event_t                 ev
);

  localparam int TW = kpe_pkg::TIME_W;

  kpe_pkg::press_t state, state_next, st;
  kpe_pkg::event_t pending, pending_next, pd;
  logic [TW-1:0]   time_mark, time_mark_next;
  logic [TW-1:0]   diff;
  logic            gt_press, gt_long, ge_repeat, gt_double, ge_twice;
  logic            dbl, lng, rpt, rres;

  // elapsed time since the mark, wrapping
  always_comb begin
    diff      = now - time_mark;
    gt_press  = diff > TW'(cfg.press_time);
    gt_long   = diff > TW'(cfg.long_press_time);
    ge_repeat = diff >= TW'(cfg.repeat_time);
    gt_double = diff > TW'(cfg.double_press_time);
    ge_twice  = diff >= TW'({cfg.press_time, 1'b0});
    dbl       = cfg.feature_enables[kpe_pkg::FEAT_DOUBLE];
    lng       = cfg.feature_enables[kpe_pkg::FEAT_LONG];
    rpt       = cfg.feature_enables[kpe_pkg::FEAT_REPEAT];
    rres      = cfg.feature_enables[kpe_pkg::FEAT_RPT_EV];
  end

  // next state and event
  always_comb begin
    st             = ctl.clear ? kpe_pkg::ST_IDLE : state;
    pd             = ctl.clear ? kpe_pkg::EV_NONE : pending;
    state_next     = st;
    pending_next   = pd;
    time_mark_next = time_mark;
    ev             = kpe_pkg::EV_NONE;
    if (pd != kpe_pkg::EV_NONE) begin
      // a held-over event goes out instead of a classifier step
      ev           = pd;
      pending_next = kpe_pkg::EV_NONE;
    end else begin
      case (st)
        kpe_pkg::ST_IDLE: begin
          if (b) begin
            state_next     = kpe_pkg::ST_PRESS;
            time_mark_next = now;
            ev             = kpe_pkg::EV_DOWN;
          end
        end
        kpe_pkg::ST_PRESS: begin
          if (!b) begin
            ev = kpe_pkg::EV_UP;
            if (dbl) begin
              state_next     = kpe_pkg::ST_PRESS2A;
              time_mark_next = now;
            end else begin
              pending_next = kpe_pkg::EV_PRESS;
              state_next   = kpe_pkg::ST_IDLE;
            end
          end
          // a fresh mark leaves no elapsed time
          if (!(!b && dbl) && gt_press) begin
            time_mark_next = now;
            if (lng) begin
              state_next = kpe_pkg::ST_PRESSL;
            end else if (rpt) begin
              ev         = kpe_pkg::EV_PRESS;
              state_next = kpe_pkg::ST_REPEAT;
            end else begin
              ev         = kpe_pkg::EV_PRESS;
              state_next = kpe_pkg::ST_WAIT;
            end
          end
        end
        kpe_pkg::ST_PRESSL: begin
          if (!b) begin
            pending_next = kpe_pkg::EV_LONG;
            ev           = kpe_pkg::EV_UP;
            state_next   = kpe_pkg::ST_IDLE;
          end else if (gt_long) begin
            if (rpt) begin
              ev             = kpe_pkg::EV_PRESS;
              state_next     = kpe_pkg::ST_REPEAT;
              time_mark_next = now;
            end else begin
              ev         = kpe_pkg::EV_LONG;
              state_next = kpe_pkg::ST_WAIT;
            end
          end
        end
        kpe_pkg::ST_REPEAT: begin
          if (!b) begin
            ev         = kpe_pkg::EV_UP;
            state_next = kpe_pkg::ST_IDLE;
          end else if (ge_repeat) begin
            ev             = rres ? kpe_pkg::EV_RPT : kpe_pkg::EV_PRESS;
            time_mark_next = now;
          end
        end
        kpe_pkg::ST_PRESS2A: begin
          if (b) begin
            ev             = kpe_pkg::EV_DOWN;
            state_next     = kpe_pkg::ST_PRESS2B;
            time_mark_next = now;
          end else if (gt_double) begin
            ev         = kpe_pkg::EV_PRESS;
            state_next = kpe_pkg::ST_IDLE;
          end
        end
        kpe_pkg::ST_PRESS2B: begin
          if (!b) begin
            ev           = kpe_pkg::EV_UP;
            pending_next = kpe_pkg::EV_DPRESS;
            state_next   = kpe_pkg::ST_IDLE;
          end
          if (ge_twice) begin
            pending_next = kpe_pkg::EV_PRESS;
            state_next   = b ? kpe_pkg::ST_WAIT : kpe_pkg::ST_IDLE;
          end
        end
        default: begin
          // wait for release, also the unused code
          if (!b) begin
            ev         = kpe_pkg::EV_UP;
            state_next = kpe_pkg::ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kpe_pkg::ST_IDLE;
      pending   <= kpe_pkg::EV_NONE;
      time_mark <= '0;
    end else if (ctl.step) begin
      state     <= state_next;
      pending   <= pending_next;
      time_mark <= time_mark_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/key_press_event_classifier.sv
// ----------------------------------------------------------------------------
// key_press_event_classifier
// Picks the key seen alone in each poll, debounces its level and classifies
// presses into key events, one result per poll.
// ----------------------------------------------------------------------------
//
//   channel     dir  handshake            payload
//   item_in     in   valid/ready          pressed_mask[15:0], now_ms[31:0]
//   result_out  out  valid/ready          key_event[2:0], key_index[3:0],
//                                         key_index_valid
//   apb         in   psel/penable/pready  paddr[4:0], pwdata/prdata[31:0]
//
// Polls flow at one per cycle while the result side is ready; an accepted
// request is held in the input register and loaded into the result register
// once that is empty or being taken. Key select, debounce and classifier
// update sit combinationally between the two registers.
// Reset (rst, synchronous) empties both registers and returns the stages and
// registers to their reset values. A stalled result holds both registers; an
// empty input register still takes one request during the stall and holds it.
//
`default_nettype none

module key_press_event_classifier (
  input  wire logic                        clk,
  input  wire logic                        rst,
  kpe_in_if.sink                           item_in,
  kpe_out_if.source                        result_out,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [kpe_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [kpe_pkg::DATA_W-1:0]  pwdata,
  output logic      [kpe_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int MW = kpe_pkg::MASK_W;
  localparam int KW = kpe_pkg::KEY_W;

  kpe_pkg::cfg_t   cfg;
  kpe_pkg::ctl_t   ctl;
  kpe_pkg::event_t ev;

  logic                       in_valid;
  logic [MW-1:0]              in_mask;
  logic [kpe_pkg::TIME_W-1:0] in_now;
  logic                       out_valid;
  logic [kpe_pkg::EV_W-1:0]   out_event;
  logic [KW-1:0]              out_index;
  logic                       out_known;
  logic [KW-1:0]              last_key, last_key_next;
  logic                       last_known, last_known_next;

  logic          take, advance;
  logic [MW-1:0] key_mask, m;
  logic          single, same, cur;
  logic [KW-1:0] idx;
  logic          filt_lvl;

  kpe_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake
  assign advance       = in_valid && (!out_valid || result_out.ready);
  assign item_in.ready = !in_valid || advance;
  assign take          = item_in.valid && item_in.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= take || (in_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_mask <= item_in.pressed_mask;
      in_now  <= item_in.now_ms;
    end
  end

  // key select: lowest set key, poll counts only with exactly one key
  always_comb begin
    for (int i = 0; i < MW; i++) begin
      key_mask[i] = (i < kpe_pkg::NUM_KEYS);
    end
    m      = in_mask & key_mask;
    single = (m != '0) && ((m & (m - MW'(1))) == '0);
    idx    = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (m[i]) idx = KW'(i);
    end
    same      = last_known && (idx == last_key);
    cur       = single && same;
    ctl.step  = advance;
    ctl.clear = single && !same;
    last_key_next   = single ? idx : last_key;
    last_known_next = single || last_known;
  end

  kpe_filter u_filter (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .cur (cur),
    .lvl (filt_lvl)
  );

  kpe_fsm u_fsm (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .cfg (cfg),
    .b   (filt_lvl),
    .now (in_now),
    .ev  (ev)
  );

  // key memory
  always_ff @(posedge clk) begin
    if (rst) begin
      last_key   <= '0;
      last_known <= 1'b0;
    end else if (advance) begin
      last_key   <= last_key_next;
      last_known <= last_known_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !result_out.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event <= ev;
      out_index <= last_key_next;
      out_known <= last_known_next;
    end
  end

  assign result_out.valid           = out_valid;
  assign result_out.key_event       = out_event;
  assign result_out.key_index       = out_index;
  assign result_out.key_index_valid = out_known;

endmodule

`default_nettype wire

FILE: hw/rtl/kpe_checker.sv
// ----------------------------------------------------------------------------
// kpe_checker
// Port-level checks on the result channel of the key press event classifier.
// ----------------------------------------------------------------------------
`default_nettype none

module kpe_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [kpe_pkg::EV_W-1:0]   key_event,
  input wire logic [kpe_pkg::KEY_W-1:0]  key_index,
  input wire logic                       key_index_valid
);

  logic seen_known;

  // remembers that a delivered result already had a known key
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_known <= 1'b0;
    end else if (out_valid && out_ready && key_index_valid) begin
      seen_known <= 1'b1;
    end
  end

  // result register is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_event)
      && $stable(key_index) && $stable(key_index_valid))
    else $error("stalled result changed");

  // event code stays within the defined set
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_event != 3'd7)
    else $error("undefined event code");

  // no key index before any key has been seen
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_index_valid |-> key_index == '0)
    else $error("key index set while no key known");

  // once a key is known it stays known
  a_known_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_known |-> key_index_valid)
    else $error("key index valid dropped");

endmodule

bind key_press_event_classifier kpe_checker u_kpe_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result_out.valid),
  .out_ready       (result_out.ready),
  .key_event       (result_out.key_event),
  .key_index       (result_out.key_index),
  .key_index_valid (result_out.key_index_valid)
);

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stand-alone check of the key press event classifier: a directed table of
// polls followed by random press, bounce and noise sequences under several
// register settings and handshake idle patterns. Every result is compared
// field by field against its typed table entry or an in-bench prediction
// of the debouncer and the press classifier.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kpe_pkg::*;

  localparam int PHASE_POLLS  = 40;
  localparam int NUM_SETTINGS = 4;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    event_t            ev;
    logic [KEY_W-1:0]  idx;
    logic              vld;
  } poll_result_t;

  typedef struct {
    logic [MASK_W-1:0] mask;
    logic [TIME_W-1:0] start_ms;
    logic [TIME_W-1:0] step_ms;
    int                reps;
    bit                typed;
    poll_result_t      want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  wire  [DATA_W-1:0] prdata;
  wire               pready;

  kpe_in_if  item_if ();
  kpe_out_if result_if ();

  key_press_event_classifier uut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_if),
    .result_out (result_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted block state
  cfg_t              cfg_now;
  phase_t            flt_phase;
  logic [FILT_W-1:0] flt_level;
  logic              flt_prev;
  press_t            press_st;
  event_t            held_event;
  logic [TIME_W-1:0] mark_ms;
  logic [KEY_W-1:0]  alone_key;
  logic              alone_known;

  poll_result_t expected_results[$];
  stim_row_t    stim_rows[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          mismatches     = 0;
  int          results_seen   = 0;
  int          polls_sent     = 0;
  int          quiet_cycles   = 0;
  int          seen_events[8];

  logic [TIME_W-1:0] poll_ms;
  int unsigned       step_lo, step_hi;

  // restart debouncer and classifier
  function automatic void clear_stages();
    flt_level  = '0;
    flt_prev   = 1'b0;
    flt_phase  = PH_WAIT_EDGE;
    press_st   = ST_IDLE;
    held_event = EV_NONE;
  endfunction

  // rc debouncer: remembered level outside the filter phase
  function automatic logic debounce_level(input logic cur);
    logic       lvl;
    logic [8:0] r;
    lvl = flt_prev;
    case (flt_phase)
      PH_WAIT_EDGE: begin
        if (!flt_prev && cur) flt_phase = PH_FILTER;
        flt_prev = cur;
      end
      PH_FILTER: begin
        r = 9'(flt_level) - 9'(flt_level >> LEAK_SHIFT);
        if (cur) begin
          r = (r + 9'(TC)) & 9'h0FF;
        end else if (r > 0) begin
          r = r - 9'd1;
        end
        lvl = (r > UTH);
        if (lvl || r < LTH) begin
          r = '0;
          flt_phase = PH_WAIT_RELEASE;
        end
        flt_level = r[FILT_W-1:0];
      end
      default: begin
        if (!cur) flt_phase = PH_WAIT_EDGE;
      end
    endcase
    return lvl;
  endfunction

  // press classifier on the debounced level
  function automatic event_t classify_press(input logic b, input logic [TIME_W-1:0] now);
    event_t k;
    logic   dbl, lng, rpt, rres;
    k    = EV_NONE;
    dbl  = cfg_now.feature_enables[FEAT_DOUBLE];
    lng  = cfg_now.feature_enables[FEAT_LONG];
    rpt  = cfg_now.feature_enables[FEAT_REPEAT];
    rres = cfg_now.feature_enables[FEAT_RPT_EV];
    if (held_event != EV_NONE) begin
      k = held_event;
      held_event = EV_NONE;
      return k;
    end
    case (press_st)
      ST_IDLE: begin
        if (b) begin
          press_st = ST_PRESS;
          mark_ms  = now;
          k        = EV_DOWN;
        end
      end
      ST_PRESS: begin
        if (!b) begin
          k = EV_UP;
          if (dbl) begin
            press_st = ST_PRESS2A;
            mark_ms  = now;
          end else begin
            held_event = EV_PRESS;
            press_st   = ST_IDLE;
          end
        end
        if ((now - mark_ms) > 32'(cfg_now.press_time)) begin
          mark_ms = now;
          if (lng) begin
            press_st = ST_PRESSL;
          end else if (rpt) begin
            k = EV_PRESS;
            press_st = ST_REPEAT;
          end else begin
            k = EV_PRESS;
            press_st = ST_WAIT;
          end
        end
      end
      ST_PRESSL: begin
        if (!b) begin
          held_event = EV_LONG;
          k          = EV_UP;
          press_st   = ST_IDLE;
        end else if ((now - mark_ms) > 32'(cfg_now.long_press_time)) begin
          if (rpt) begin
            k        = EV_PRESS;
            press_st = ST_REPEAT;
            mark_ms  = now;
          end else begin
            k        = EV_LONG;
            press_st = ST_WAIT;
          end
        end
      end
      ST_REPEAT: begin
        if (!b) begin
          k        = EV_UP;
          press_st = ST_IDLE;
        end else if ((now - mark_ms) >= 32'(cfg_now.repeat_time)) begin
          k       = rres ? EV_RPT : EV_PRESS;
          mark_ms = now;
        end
      end
      ST_PRESS2A: begin
        if (b) begin
          k        = EV_DOWN;
          press_st = ST_PRESS2B;
          mark_ms  = now;
        end
        if ((now - mark_ms) > 32'(cfg_now.double_press_time)) begin
          k        = EV_PRESS;
          press_st = b ? ST_WAIT : ST_IDLE;
        end
      end
      ST_PRESS2B: begin
        if (!b) begin
          k          = EV_UP;
          held_event = EV_DPRESS;
          press_st   = ST_IDLE;
        end
        // release timeout is twice the press time, 17 bits wide
        if ((now - mark_ms) >= {15'd0, cfg_now.press_time, 1'b0}) begin
          held_event = EV_PRESS;
          press_st   = b ? ST_WAIT : ST_IDLE;
        end
      end
      default: begin
        if (!b) begin
          k        = EV_UP;
          press_st = ST_IDLE;
        end
      end
    endcase
    return k;
  endfunction

  // one poll: pick the key seen alone, debounce, classify
  function automatic poll_result_t predict_poll(input logic [MASK_W-1:0] mask,
                                                input logic [TIME_W-1:0] now);
    poll_result_t     res;
    int               hits;
    int               i;
    logic [KEY_W-1:0] first;
    logic             lvl;
    logic             same;
    hits  = 0;
    first = '0;
    lvl   = 1'b0;
    for (i = 0; i < NUM_KEYS && i < MASK_W; i++) begin
      if (mask[i]) begin
        if (hits == 0) first = i[KEY_W-1:0];
        hits++;
      end
    end
    if (hits == 1) begin
      same = alone_known && (first == alone_key);
      if (!same) clear_stages();
      lvl         = same;
      alone_key   = first;
      alone_known = 1'b1;
    end
    res.ev  = classify_press(debounce_level(lvl), now);
    res.idx = alone_key;
    res.vld = alone_known;
    return res;
  endfunction

  // mismatch report
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // apb register write: setup, then access, then back to idle
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PRESS_TIME:  cfg_now.press_time        = value[CFG_TIME_W-1:0];
      REG_DOUBLE_TIME: cfg_now.double_press_time = value[CFG_TIME_W-1:0];
      REG_LONG_TIME:   cfg_now.long_press_time   = value[CFG_TIME_W-1:0];
      REG_REPEAT_TIME: cfg_now.repeat_time       = value[CFG_TIME_W-1:0];
      REG_FEATURES:    cfg_now.feature_enables   = value[FEAT_W-1:0];
      default: ;
    endcase
  endtask

  // drive one request, wait for acceptance, queue its typed or predicted result
  task automatic send_poll(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] now,
                           input bit typed, input poll_result_t want);
    poll_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid        <= 1'b1;
    item_if.pressed_mask <= mask;
    item_if.now_ms       <= now;
    do @(posedge clk); while (!item_if.ready);
    predicted = predict_poll(mask, now);
    expected_results.push_back(typed ? want : predicted);
    polls_sent++;
  endtask

  // random poll: advance the millisecond clock and send
  task automatic advance_and_send(input logic [MASK_W-1:0] mask);
    poll_ms = poll_ms + $urandom_range(step_hi, step_lo);
    send_poll(mask, poll_ms, 1'b0, '0);
  endtask

  task automatic add_row(input logic [MASK_W-1:0] mask, input logic [TIME_W-1:0] start_ms,
                         input logic [TIME_W-1:0] step_ms, input int reps, input bit typed,
                         input event_t ev, input logic [KEY_W-1:0] idx, input logic vld);
    stim_row_t row;
    row.mask      = mask;
    row.start_ms  = start_ms;
    row.step_ms   = step_ms;
    row.reps      = reps;
    row.typed     = typed;
    row.want.ev   = ev;
    row.want.idx  = idx;
    row.want.vld  = vld;
    stim_rows.push_back(row);
  endtask

  // result check and receiver stall
  always @(posedge clk) begin
    poll_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, key_event", result_if.key_event, 0);
      end else begin
        want = expected_results.pop_front();
        if (result_if.key_event !== want.ev)
          report_mismatch("key_event", result_if.key_event, want.ev);
        if (result_if.key_index !== want.idx)
          report_mismatch("key_index", result_if.key_index, want.idx);
        if (result_if.key_index_valid !== want.vld)
          report_mismatch("key_index_valid", result_if.key_index_valid, want.vld);
        seen_events[want.ev]++;
      end
      results_seen++;
    end
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                r;
    int                setting;
    int                phase_start;
    int                pick;
    int                n;
    int                extra;
    bit                paused;
    logic [KEY_W-1:0]  key;
    logic [CFG_TIME_W-1:0] t_press, t_double, t_long, t_repeat;
    logic [FEAT_W-1:0] feat;

    // known values on every input from time zero
    item_if.valid        = 1'b0;
    item_if.pressed_mask = '0;
    item_if.now_ms       = '0;
    result_if.ready      = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    poll_ms = '0;
    step_lo = 0;
    step_hi = 1;
    paused  = 1'b0;
    foreach (seen_events[i]) seen_events[i] = 0;

    // predicted reset state
    cfg_now.press_time        = PRESS_TIME_RST;
    cfg_now.double_press_time = DOUBLE_TIME_RST;
    cfg_now.long_press_time   = LONG_TIME_RST;
    cfg_now.repeat_time       = REPEAT_TIME_RST;
    cfg_now.feature_enables   = FEATURES_RST;
    clear_stages();
    mark_ms     = '0;
    alone_key   = '0;
    alone_known = 1'b0;

    // directed table: mask, start ms, step ms, repeats, typed result
    add_row(16'h0000, 32'h0000_0000, 0, 1, 1, EV_NONE, 4'd0, 1'b0);   // idle after reset
    add_row(16'hFFFF, 32'hFFFF_FFFF, 0, 1, 1, EV_NONE, 4'd0, 1'b0);   // every key at once
    add_row(16'h0003, 32'h0000_0001, 0, 1, 1, EV_NONE, 4'd0, 1'b0);   // two keys
    add_row(16'h8000, 32'h0000_0002, 0, 1, 1, EV_NONE, 4'd15, 1'b1);  // top key seen first
    add_row(16'h0001, 32'h0000_0003, 0, 1, 1, EV_NONE, 4'd0, 1'b1);   // key change restarts
    add_row(16'h0001, 32'h0000_0004, 0, 1, 1, EV_NONE, 4'd0, 1'b1);   // rising edge
    add_row(16'h0001, 32'h0000_0005, 0, 1, 1, EV_NONE, 4'd0, 1'b1);   // filter still low
    add_row(16'h0000, 32'h0000_0006, 0, 1, 1, EV_NONE, 4'd0, 1'b1);   // decays below low mark
    add_row(16'h0000, 32'h0000_0007, 1, 4, 0, EV_NONE, 4'd0, 1'b0);   // remembered level replays
    add_row(16'h0004, 32'h0000_0064, 2, 90, 0, EV_NONE, 4'd0, 1'b0);  // key 2 through the filter
    add_row(16'h0004, 32'h0000_0118, 25, 12, 0, EV_NONE, 4'd0, 1'b0); // held past press time
    add_row(16'h0000, 32'h0000_0258, 1, 5, 0, EV_NONE, 4'd0, 1'b0);   // release
    add_row(16'h0006, 32'h0000_0316, 1, 2, 0, EV_NONE, 4'd0, 1'b0);   // two keys while released
    add_row(16'hAAAA, 32'h0000_0318, 0, 1, 0, EV_NONE, 4'd0, 1'b0);
    add_row(16'h5555, 32'h0000_0319, 0, 1, 0, EV_NONE, 4'd0, 1'b0);
    add_row(16'h0400, 32'hFFFF_FFC0, 1, 90, 0, EV_NONE, 4'd0, 1'b0);  // held across the wrap
    add_row(16'h0000, 32'h0000_0020, 1, 5, 0, EV_NONE, 4'd0, 1'b0);
    add_row(16'h0010, 32'h8000_0000, 0, 1, 0, EV_NONE, 4'd0, 1'b0);   // new key, high timestamp

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    foreach (stim_rows[i]) begin
      for (r = 0; r < stim_rows[i].reps; r++)
        send_poll(stim_rows[i].mask, stim_rows[i].start_ms + r * stim_rows[i].step_ms,
                  stim_rows[i].typed, stim_rows[i].want);
    end
    poll_ms = 32'h8000_0000;

    for (setting = 0; setting < NUM_SETTINGS; setting++) begin
      // block idle before touching registers
      item_if.valid <= 1'b0;
      do @(posedge clk); while (expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clk);

      case (setting)
        0: begin
          t_press = 16'd150; t_double = 16'd250; t_long = 16'd600; t_repeat = 16'd300;
          feat = 4'b0000;
        end
        1: begin
          t_press = 16'd0; t_double = 16'd0; t_long = 16'd0; t_repeat = 16'd0;
          feat = 4'b1111;
        end
        2: begin
          t_press = 16'hFFFF; t_double = 16'hFFFF; t_long = 16'hFFFF; t_repeat = 16'hFFFF;
          feat = 4'b1111;
        end
        default: begin
          t_press  = 16'($urandom_range(400, 20));
          t_double = 16'($urandom_range(400, 20));
          t_long   = 16'($urandom_range(400, 20));
          t_repeat = 16'($urandom_range(400, 20));
          feat     = 4'($urandom_range(15));
        end
      endcase
      write_reg(REG_PRESS_TIME, 32'(t_press));
      write_reg(REG_DOUBLE_TIME, 32'(t_double));
      write_reg(REG_LONG_TIME, 32'(t_long));
      write_reg(REG_REPEAT_TIME, 32'(t_repeat));
      write_reg(REG_FEATURES, 32'(feat));

      // handshake idle pattern for this phase
      case (setting % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase

      phase_start = polls_sent;
      while (polls_sent - phase_start < PHASE_POLLS) begin
        // sender holds off once until the pipeline has drained
        if (setting == 1 && !paused && polls_sent - phase_start >= PHASE_POLLS / 2) begin
          paused = 1'b1;
          item_if.valid <= 1'b0;
          do @(posedge clk); while (expected_results.size() != 0);
        end

        case ($urandom_range(3))
          0: begin step_lo = 0;  step_hi = 3;   end
          1: begin step_lo = 1;  step_hi = 20;  end
          2: begin step_lo = 20; step_hi = 300; end
          default: begin step_lo = 0; step_hi = 60; end
        endcase

        pick = $urandom_range(99);
        if (pick < 78) begin
          // well-formed press: hold through the filter, then release
          key = ($urandom_range(3) == 0) ? KEY_W'($urandom_range(15)) : alone_key;
          n = 0;
          do begin
            advance_and_send(($urandom_range(49) == 0) ? 16'h0000 : (16'h0001 << key));
            n++;
          end while ((n < 2 || flt_phase != PH_WAIT_RELEASE) && n < 120);
          extra = ($urandom_range(4) == 0) ? $urandom_range(100, 30) : $urandom_range(15, 0);
          repeat (extra) advance_and_send(16'h0001 << key);
          repeat ($urandom_range(8, 1)) advance_and_send(16'h0000);
        end else if (pick < 93) begin
          // noise: random masks, mostly several keys
          repeat ($urandom_range(6, 1)) advance_and_send(MASK_W'($urandom));
        end else begin
          // timestamp jump
          poll_ms = $urandom;
        end
      end
    end

    // wait out the last results
    item_if.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d results from %0d polls: directed table, then presses and noise over %0d settings",
             results_seen, polls_sent, NUM_SETTINGS);
    $display("events seen: down %0d up %0d press %0d double %0d long %0d repeat %0d",
             seen_events[EV_DOWN], seen_events[EV_UP], seen_events[EV_PRESS],
             seen_events[EV_DPRESS], seen_events[EV_LONG], seen_events[EV_RPT]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
